FILE: rtl/lrk4_pkg.sv
// shared types, constants and arithmetic helpers for the lorenz rk4 integrator
// no dependencies
package lrk4_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NUM_REGS = 7;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_SIGMA = 3'd0;
	localparam logic [IDX_W-1:0] REG_RHO = 3'd1;
	localparam logic [IDX_W-1:0] REG_BETA = 3'd2;
	localparam logic [IDX_W-1:0] REG_DT = 3'd3;
	localparam logic [IDX_W-1:0] REG_SX = 3'd4;
	localparam logic [IDX_W-1:0] REG_SY = 3'd5;
	localparam logic [IDX_W-1:0] REG_SZ = 3'd6;

	localparam logic signed [31:0] MAX32 = 32'sh7fffffff;
	localparam logic signed [31:0] MIN32 = 32'sh80000000;

	// floor((s+3)/6): bias by 3 + 6*2^32 to go positive, halve, then divide by
	// three as a*(2^18-1)/3 + (a+b)/3 with u = a*2^18 + b
	localparam logic [35:0] DIV_BIAS = 36'd25769803779;
	localparam logic [16:0] RECIP3_HI = 17'd87381;
	localparam logic [17:0] RECIP3_LO = 18'd174763;

	// datapath operations, one per controller step
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,   // load start position
		OP_STAGE,  // copy p into stage point, clear sums
		OP_DIFF,   // form y-x and rho-z
		OP_MDX,    // k.x = sigma*(y-x)
		OP_MDY,    // k.y = x*(rho-z) - y
		OP_MXY,    // t = x*y
		OP_MDZ,    // k.z = t - beta*z
		OP_ACC,    // accumulate k with weight
		OP_MSTG,   // stage point component = p + dt*k/(1 or 2)
		OP_DIVA,   // first half of avg = round(sum/6)
		OP_DIVB,   // second half of avg = round(sum/6)
		OP_UPD     // p component += dt*avg
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] comp;   // component 0..2
		logic       half;   // shift FRAC_BITS+1
		logic       dbl;    // accumulate twice k
	} cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'(signed'(MAX32))) return MAX32;
		if (v < 66'(signed'(MIN32))) return MIN32;
		return v[31:0];
	endfunction

endpackage

FILE: rtl/lrk4_datapath.sv
// datapath: position, stage point, k vector, sums and one shared multiplier
// depends on lrk4_pkg
module lrk4_datapath (
	input  logic clk,
	input  logic arst_n,
	input  lrk4_pkg::cmd_t cmd,
	input  logic signed [31:0] coef_sigma,
	input  logic signed [31:0] coef_rho,
	input  logic signed [31:0] coef_beta,
	input  logic [30:0] time_step,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	output logic [31:0] pos_x,
	output logic [31:0] pos_y,
	output logic [31:0] pos_z
);
	import lrk4_pkg::*;

	logic signed [31:0] p_q [3];
	logic signed [31:0] s_q [3];   // stage point
	logic signed [31:0] k_q [3];
	logic signed [34:0] sum_q [3];
	logic signed [31:0] dyx_q, rz_q, t_q;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [65:0] rnd;
	logic signed [31:0] mres;
	logic [1:0] c;
	logic [35:0] div_n;
	logic [16:0] div_a;
	logic [17:0] div_b;
	logic [18:0] div_v;
	logic [33:0] div_hi;
	logic [36:0] div_p;
	logic [33:0] div_q;
	logic [18:0] div_v_q;
	logic [33:0] div_hi_q;
	logic signed [31:0] avg_q;

	assign c = cmd.comp;

	always_comb begin
		ma = coef_sigma;
		mb = dyx_q;
		case (cmd.op)
			OP_MDX: begin ma = coef_sigma; mb = dyx_q; end
			OP_MDY: begin ma = s_q[0]; mb = rz_q; end
			OP_MXY: begin ma = s_q[0]; mb = s_q[1]; end
			OP_MDZ: begin ma = coef_beta; mb = s_q[2]; end
			OP_MSTG: begin ma = {1'b0, time_step}; mb = k_q[c]; end
			OP_UPD: begin ma = {1'b0, time_step}; mb = avg_q; end
			default: begin ma = coef_sigma; mb = dyx_q; end
		endcase
	end

	always_comb begin
		prod = ma * mb;
		if (cmd.half)
			rnd = (66'(prod) + (66'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
		else
			rnd = (66'(prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		mres = sat32(rnd);
	end

	// divide by six in two steps, low 32 bits of the biased quotient are the average
	always_comb begin
		div_n = 36'(sum_q[c]) + DIV_BIAS;
		div_a = div_n[35:19];
		div_b = div_n[18:1];
		div_v = {2'b00, div_a} + {1'b0, div_b};
		div_hi = {17'd0, div_a} * {17'd0, RECIP3_HI};
		div_p = {18'd0, div_v_q} * {19'd0, RECIP3_LO};
		div_q = div_hi_q + {16'd0, div_p[36:19]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q[0] <= 32'sd65536;
			p_q[1] <= 32'sd65536;
			p_q[2] <= 32'sd65536;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					p_q[0] <= start_x;
					p_q[1] <= start_y;
					p_q[2] <= start_z;
				end
				OP_UPD: p_q[c] <= sat32(66'(p_q[c]) + 66'(mres));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_STAGE: begin
				s_q <= p_q;
				sum_q[0] <= '0;
				sum_q[1] <= '0;
				sum_q[2] <= '0;
			end
			OP_DIFF: begin
				dyx_q <= sat32(66'(s_q[1]) - 66'(s_q[0]));
				rz_q <= sat32(66'(coef_rho) - 66'(s_q[2]));
			end
			OP_MDX: k_q[0] <= mres;
			OP_MDY: k_q[1] <= sat32(66'(mres) - 66'(s_q[1]));
			OP_MXY: t_q <= mres;
			OP_MDZ: k_q[2] <= sat32(66'(t_q) - 66'(mres));
			OP_ACC: sum_q[c] <= sum_q[c] + (cmd.dbl ? 35'(k_q[c]) <<< 1 : 35'(k_q[c]));
			OP_MSTG: s_q[c] <= sat32(66'(p_q[c]) + 66'(mres));
			OP_DIVA: begin
				div_v_q <= div_v;
				div_hi_q <= div_hi;
			end
			OP_DIVB: avg_q <= div_q[31:0];
			default: ;
		endcase
	end

	assign pos_x = p_q[0];
	assign pos_y = p_q[1];
	assign pos_z = p_q[2];
endmodule

FILE: rtl/lrk4_ctrl.sv
// controller: sequences one rk4 step as a fixed list of datapath commands
// depends on lrk4_pkg
module lrk4_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic restart,
	input  logic out_free,
	output logic busy,
	output logic done,
	output lrk4_pkg::cmd_t cmd
);
	import lrk4_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_RUN  = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [6:0] step_q;
	logic [1:0] ev_q;   // evaluation number 0..3
	logic last;

	// per evaluation: DIFF,MDX,MDY,MXY,MDZ, then 3x(ACC, MSTG) = 11 steps
	// final: 3x(DIVA,DIVB,UPD) = 9 steps
	always_comb begin
		cmd = '{op: OP_NONE, comp: 2'd0, half: 1'b0, dbl: 1'b0};
		last = 1'b0;
		if (state_q == ST_LOAD) cmd.op = OP_LOAD;
		if (state_q == ST_RUN) begin
			if (ev_q == 2'd0 && step_q == 7'd0) cmd.op = OP_STAGE;
			else begin
				case (step_q)
					7'd1: cmd.op = OP_DIFF;
					7'd2: cmd.op = OP_MDX;
					7'd3: cmd.op = OP_MDY;
					7'd4: cmd.op = OP_MXY;
					7'd5: cmd.op = OP_MDZ;
					7'd6, 7'd8, 7'd10: begin
						cmd.op = OP_ACC;
						cmd.comp = 2'((step_q - 7'd6) >> 1);
						cmd.dbl = (ev_q == 2'd1) || (ev_q == 2'd2);
					end
					7'd7, 7'd9, 7'd11: begin
						cmd.op = (ev_q == 2'd3) ? OP_NONE : OP_MSTG;
						cmd.comp = 2'((step_q - 7'd7) >> 1);
						cmd.half = (ev_q != 2'd2);
					end
					7'd12: begin cmd.op = OP_DIVA; cmd.comp = 2'd0; end
					7'd13: begin cmd.op = OP_DIVB; cmd.comp = 2'd0; end
					7'd14: begin cmd.op = OP_UPD; cmd.comp = 2'd0; end
					7'd15: begin cmd.op = OP_DIVA; cmd.comp = 2'd1; end
					7'd16: begin cmd.op = OP_DIVB; cmd.comp = 2'd1; end
					7'd17: begin cmd.op = OP_UPD; cmd.comp = 2'd1; end
					7'd18: begin cmd.op = OP_DIVA; cmd.comp = 2'd2; end
					7'd19: begin cmd.op = OP_DIVB; cmd.comp = 2'd2; end
					7'd20: begin
						cmd.op = OP_UPD;
						cmd.comp = 2'd2;
						last = 1'b1;
					end
					default: cmd.op = OP_NONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			ev_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (start) begin
					state_q <= restart ? ST_LOAD : ST_RUN;
					step_q <= '0;
					ev_q <= '0;
				end
				ST_LOAD: state_q <= ST_DONE;
				ST_RUN: begin
					if (last) state_q <= ST_DONE;
					else if (step_q == 7'd11 && ev_q != 2'd3) begin
						step_q <= 7'd1;
						ev_q <= ev_q + 2'd1;
					end else step_q <= step_q + 7'd1;
				end
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE) && out_free;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> state_q == ST_DONE) else $error("load did not finish");
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && last) |-> ev_q == 2'd3) else $error("early finish");
endmodule

FILE: rtl/lorenz_rk4_integrator_core.sv
// top level of the lorenz rk4 integrator: config registers, handshake, output register
// depends on lrk4_pkg, lrk4_ctrl, lrk4_datapath
//
// channel   dir  tdata / tuser
// s_axis    in   tdata[0] restart
// m_axis    out  tdata[31:0] pos_x_out, [63:32] pos_y_out, [95:64] pos_z_out
// cfg       in   cfg_we, cfg_idx, cfg_data
//
// a step runs from accept to result through one shared multiplier as 54 sequencer
// steps, then the done state; a restart goes through the load and done states
// the next item is accepted once the result moves into the output register
// a full output register that is not taken holds the block in done
// arst_n clears control and sets the position to one
module lorenz_rk4_integrator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // restart, zero pad
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [95:0] m_axis_tdata,  // pos_x_out, pos_y_out, pos_z_out
	input  logic cfg_we,
	input  logic [lrk4_pkg::IDX_W-1:0] cfg_idx,
	input  logic [31:0] cfg_data
);
	import lrk4_pkg::*;

	logic signed [31:0] sigma_q, rho_q, beta_q, sx_q, sy_q, sz_q;
	logic [30:0] dt_q;
	logic busy, done, start, out_free;
	logic [31:0] px, py, pz;
	cmd_t cmd;
	logic restart;

	assign restart = s_axis_tdata[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= 32'sd655360;
			rho_q <= 32'sd1835008;
			beta_q <= 32'sd174763;
			dt_q <= 31'd655;
			sx_q <= 32'sd65536;
			sy_q <= 32'sd65536;
			sz_q <= 32'sd65536;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SIGMA: sigma_q <= cfg_data;
				REG_RHO: rho_q <= cfg_data;
				REG_BETA: beta_q <= cfg_data;
				REG_DT: dt_q <= cfg_data[30:0];
				REG_SX: sx_q <= cfg_data;
				REG_SY: sy_q <= cfg_data;
				REG_SZ: sz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !busy;
	assign start = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;

	lrk4_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .restart(restart),
		.out_free(out_free), .busy(busy), .done(done), .cmd(cmd)
	);

	lrk4_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.coef_sigma(sigma_q), .coef_rho(rho_q), .coef_beta(beta_q), .time_step(dt_q),
		.start_x(sx_q), .start_y(sy_q), .start_z(sz_q),
		.pos_x(px), .pos_y(py), .pos_z(pz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (done) m_axis_tvalid <= 1'b1;
		else if (m_axis_tready) m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) m_axis_tdata <= {pz, py, px};
	end
endmodule
